// ===== sv/ctc_pkg.sv =====
// shared constants and types for the currency text to cents converter
package ctc_pkg;

    localparam int MAX_LENGTH_DEF = 32;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int WHOLE_W  = 54;
    localparam int MAG_W    = 60;
    localparam int CENTS_W  = 61;
    localparam int FRAC_W   = 7;
    localparam int FCNT_W   = 2;

    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] DIGIT_BASE  = 8'd48;
    localparam logic [CHAR_W-1:0] DIGIT_TOP   = 8'd57;

    localparam logic [FCNT_W-1:0] FRAC_DIGITS = 2'd2;
    localparam logic [FCNT_W-1:0] FRAC_ONE    = 2'd1;

    localparam logic [WHOLE_W-1:0] MAX_WHOLE = 54'd9999999999999999;
    localparam logic [MAG_W-1:0]   MAX_CENTS = 60'd999999999999999999;

    // state captured on the last character of a string
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic               over;
        logic [FRAC_W-1:0]  pending;
        logic [FCNT_W-1:0]  fcount;
        logic               point;
        logic               too_long;
        logic               sign;
    } t_snap;

    // unsigned magnitude with flags, before the sign is applied
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             sign;
        logic             too_long;
        logic             over;
    } t_mag;

endpackage

// ===== sv/ctc_parse.sv =====
// input register and per-character parse state
module ctc_parse import ctc_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    output logic              o_snap_valid,
    input  logic              i_snap_stall,
    output t_snap             o_snap
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);

    logic               r_a_valid;
    logic [CHAR_W-1:0]  r_a_char;
    logic               r_a_last;

    logic [WHOLE_W-1:0] r_total, n_total;
    logic               r_total_over, n_total_over;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic               r_over_seen, n_over_seen;
    logic [FRAC_W-1:0]  r_pending, n_pending;
    logic [FCNT_W-1:0]  r_fcount, n_fcount;
    logic               r_point, n_point;
    logic               r_sign, n_sign;
    logic               r_dollar, n_dollar;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_len_over, n_len_over;

    logic               a_stall;
    logic               a_fire;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [WHOLE_W+2:0] total_x10;
    logic [FRAC_W-1:0]  pending_x10;

    assign a_stall = r_a_valid && r_a_last && i_snap_stall;
    assign a_fire  = r_a_valid && !a_stall;
    assign o_stall = a_stall;

    assign is_digit = (r_a_char >= DIGIT_BASE) && (r_a_char <= DIGIT_TOP);
    assign digit    = r_a_char[DIGIT_W-1:0];

    // value times ten plus the new digit
    assign total_x10 = {r_total, 3'b000} + {2'b00, r_total, 1'b0}
                     + {{(WHOLE_W-1){1'b0}}, digit};
    assign pending_x10 = FRAC_W'({r_pending, 3'b000} + {2'b00, r_pending, 1'b0}
                       + {{(FRAC_W-1){1'b0}}, digit});

    always_comb begin
        n_total      = r_total;
        n_total_over = r_total_over;
        n_whole      = r_whole;
        n_over_seen  = r_over_seen;
        n_pending    = r_pending;
        n_fcount     = r_fcount;
        n_point      = r_point;
        n_sign       = r_sign;
        n_dollar     = r_dollar;
        n_count      = r_count;
        n_len_over   = r_len_over;

        if (r_count >= CNT_W'(MAX_LENGTH)) begin
            n_len_over = 1'b1;
        end else begin
            n_count = r_count + CNT_W'(1);
        end

        case (r_a_char)
            CHAR_POINT: begin
                n_whole     = r_total;
                n_over_seen = r_total_over;
                n_pending   = '0;
                n_fcount    = '0;
                n_point     = 1'b1;
            end
            CHAR_DOLLAR: begin
                n_dollar = 1'b1;
            end
            CHAR_MINUS: begin
                if (!r_dollar) begin
                    n_sign = !r_sign;
                end
            end
            default: begin
                if (is_digit) begin
                    if (!r_total_over) begin
                        if (total_x10 > {3'b000, MAX_WHOLE}) begin
                            n_total_over = 1'b1;
                        end else begin
                            n_total = total_x10[WHOLE_W-1:0];
                        end
                    end
                    if (r_point && (r_fcount < FRAC_DIGITS)) begin
                        n_pending = pending_x10;
                        n_fcount  = r_fcount + FCNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_comb begin
        o_snap_valid    = r_a_valid && r_a_last;
        o_snap.whole    = n_point ? n_whole : n_total;
        o_snap.over     = n_point ? n_over_seen : n_total_over;
        o_snap.pending  = n_pending;
        o_snap.fcount   = n_fcount;
        o_snap.point    = n_point;
        o_snap.too_long = n_len_over;
        o_snap.sign     = n_sign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!a_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!a_stall && i_valid) begin
            r_a_char <= i_char_code;
            r_a_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (a_fire && r_a_last)) begin
            r_total      <= '0;
            r_total_over <= 1'b0;
            r_whole      <= '0;
            r_over_seen  <= 1'b0;
            r_pending    <= '0;
            r_fcount     <= '0;
            r_point      <= 1'b0;
            r_sign       <= 1'b0;
            r_dollar     <= 1'b0;
            r_count      <= '0;
            r_len_over   <= 1'b0;
        end else if (a_fire) begin
            r_total      <= n_total;
            r_total_over <= n_total_over;
            r_whole      <= n_whole;
            r_over_seen  <= n_over_seen;
            r_pending    <= n_pending;
            r_fcount     <= n_fcount;
            r_point      <= n_point;
            r_sign       <= n_sign;
            r_dollar     <= n_dollar;
            r_count      <= n_count;
            r_len_over   <= n_len_over;
        end
    end

    // a string's last character leaves clean state for the next string
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire && r_a_last |=> (r_count == '0) && !r_point && !r_sign && !r_total_over)
        else $error("parse state not cleared after last character");

endmodule

// ===== sv/ctc_scale.sv =====
// snapshot register and cents magnitude
module ctc_scale import ctc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_snap_valid,
    output logic  o_snap_stall,
    input  t_snap i_snap,
    output logic  o_mag_valid,
    input  logic  i_mag_stall,
    output t_mag  o_mag
);

    logic              r_s_valid;
    t_snap             r_s;
    logic [FRAC_W-1:0] frac;
    logic [MAG_W-1:0]  whole_x100;

    assign o_snap_stall = r_s_valid && i_mag_stall;
    assign o_mag_valid  = r_s_valid;

    always_comb begin
        if (!r_s.point) begin
            frac = '0;
        end else if (r_s.fcount == FRAC_ONE) begin
            frac = FRAC_W'({r_s.pending, 3'b000} + {2'b00, r_s.pending, 1'b0});
        end else begin
            frac = r_s.pending;
        end
    end

    // times 100 as 64 + 32 + 4
    assign whole_x100 = {r_s.whole, 6'b0} + {1'b0, r_s.whole, 5'b0}
                      + {4'b0, r_s.whole, 2'b0} + {{(MAG_W-FRAC_W){1'b0}}, frac};

    always_comb begin
        o_mag.sign     = r_s.sign;
        o_mag.too_long = r_s.too_long;
        o_mag.over     = !r_s.too_long && r_s.over;
        if (r_s.too_long) begin
            o_mag.mag = '0;
        end else if (r_s.over) begin
            o_mag.mag = MAX_CENTS;
        end else begin
            o_mag.mag = whole_x100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (!o_snap_stall) begin
            r_s_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_snap_stall && i_snap_valid) begin
            r_s <= i_snap;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> o_mag.mag <= MAX_CENTS)
        else $error("cents magnitude beyond saturation limit");

endmodule

// ===== sv/ctc_sign.sv =====
// magnitude register and two's complement sign
module ctc_sign import ctc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mag_valid,
    output logic               o_mag_stall,
    input  t_mag               i_mag,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [CENTS_W-1:0] o_cents,
    output logic               o_too_long,
    output logic               o_overflowed
);

    logic r_m_valid;
    t_mag r_m;

    assign o_mag_stall  = r_m_valid && i_res_stall;
    assign o_res_valid  = r_m_valid;
    assign o_cents      = r_m.sign ? (CENTS_W'(0) - {1'b0, r_m.mag}) : {1'b0, r_m.mag};
    assign o_too_long   = r_m.too_long;
    assign o_overflowed = r_m.over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (!o_mag_stall) begin
            r_m_valid <= i_mag_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_mag_stall && i_mag_valid) begin
            r_m <= i_mag;
        end
    end

endmodule

// ===== sv/currency_text_to_cents.sv =====
// top level of the money string to signed cents converter
//
// takes one ascii character per word and returns one word on the character
// flagged last: the amount in signed cents (61 bits, two's complement), a
// too_long flag and an overflowed flag. digits before the last '.' are the
// whole part; the first two digits after it are cents, further ones are
// dropped; a later '.' folds all digits after the earlier '.' into the whole
// part; each '-' before the first '$' flips the sign; anything else is
// skipped. strings longer than MAX_LENGTH give zero with too_long set, and a
// whole part above 9999999999999999 saturates cents to +-999999999999999999
// with overflowed set. one character is taken every cycle with no gaps
// between strings while o_stall is low; the figure is set by the parse
// step (times ten, add and compare against the limit) between the input
// register and the state. the result word passes from the input register
// through the snapshot and magnitude registers to the output register;
// a stalled output word holds a stage only while the stage ahead of it
// is full, so the input stalls once four last characters wait in the pipe
module currency_text_to_cents import ctc_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_last_char,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CENTS_W-1:0] o_cents,
    output logic               o_too_long,
    output logic               o_overflowed
);

    // snapshot of the parse state on a last character
    logic               snap_valid;
    logic               snap_stall;
    t_snap              snap;

    // unsigned magnitude and flags
    logic               mag_valid;
    logic               mag_stall;
    t_mag               mag;

    // signed result ahead of the output register
    logic               res_valid;
    logic               res_stall;
    logic [CENTS_W-1:0] res_cents;
    logic               res_too_long;
    logic               res_over;

    // output register
    logic               r_o_valid;
    logic [CENTS_W-1:0] r_cents;
    logic               r_too_long;
    logic               r_over;

    ctc_parse #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_snap_valid (snap_valid),
        .i_snap_stall (snap_stall),
        .o_snap       (snap)
    );

    ctc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_stall (snap_stall),
        .i_snap       (snap),
        .o_mag_valid  (mag_valid),
        .i_mag_stall  (mag_stall),
        .o_mag        (mag)
    );

    ctc_sign u_sign (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mag_valid  (mag_valid),
        .o_mag_stall  (mag_stall),
        .i_mag        (mag),
        .o_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .o_cents      (res_cents),
        .o_too_long   (res_too_long),
        .o_overflowed (res_over)
    );

    // output word holds while the consumer stalls
    assign res_stall = r_o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!res_stall) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!res_stall && res_valid) begin
            r_cents    <= res_cents;
            r_too_long <= res_too_long;
            r_over     <= res_over;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_cents      = r_cents;
    assign o_too_long   = r_too_long;
    assign o_overflowed = r_over;

    // an over-length string reports zero and no overflow
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_long |-> (o_cents == '0) && !o_overflowed)
        else $error("too_long word carries nonzero cents or overflow");

    // overflow always reports the saturated magnitude
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |->
            (o_cents == CENTS_W'(MAX_CENTS)) ||
            (o_cents == (CENTS_W'(0) - CENTS_W'(MAX_CENTS))))
        else $error("overflowed word not saturated");

endmodule
